/* src/k_nearest_heap_select_defines.svh */
// assertion macros shared by the k-nearest selection rtl
// expects signals named clock and reset in the including module
`ifndef K_NEAREST_HEAP_SELECT_DEFINES_SVH
`define K_NEAREST_HEAP_SELECT_DEFINES_SVH

// property checked on every edge outside reset
`define KNHS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define KNHS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* src/knhs_pkg.sv */
// shared types and codes of the k-nearest selection block
// no dependencies
package knhs_pkg;

   localparam logic [1:0] REQ_OFFER = 2'd0;
   localparam logic [1:0] REQ_BEGIN = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic CSR_KEEP_COUNT   = 1'b0;
   localparam logic CSR_SEARCH_LIMIT = 1'b1;

   localparam int DIST_BITS  = 32;
   localparam int ID_PORT    = 20;
   localparam int TOTAL_BITS = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND,
      ST_EVSCAN,
      ST_EVWRITE,
      ST_STSCAN,
      ST_READSCAN,
      ST_EMIT
   } state_type;

endpackage

/* src/knhs_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module knhs_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

/* src/k_nearest_heap_select.sv */
// Keeps up to keep_count candidates (distance, id) of one search in a
// single-port-read memory; an offer into a full store replaces the farthest
// held entry. Every step scans the held entries through the one read port,
// one entry per cycle: an append is a write and a bound scan, a full offer
// an eviction scan, write and bound scan, a read-out one selection scan per
// emitted entry. Requests are stalled while a request is in work.
// depends on knhs_pkg, knhs_ram and k_nearest_heap_select_defines.svh
`include "k_nearest_heap_select_defines.svh"

module k_nearest_heap_select #(
   parameter int MAX_KEEP = 64,
   parameter int ID_BITS  = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [19:0] req_candidate_id,
   input  logic [31:0] req_candidate_dist2,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_bound_dist2,
   output logic        rsp_store_full,
   output logic [6:0]  rsp_kept_total,
   output logic        rsp_entry_valid,
   output logic [19:0] rsp_out_id,
   output logic [31:0] rsp_out_dist2,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [31:0] csr_write_data
);
   localparam int AW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CW  = $clog2(MAX_KEEP + 1);
   localparam int IDW = (ID_BITS < knhs_pkg::ID_PORT) ? ID_BITS : knhs_pkg::ID_PORT;
   localparam int DW  = knhs_pkg::DIST_BITS;
   localparam int EW  = DW + IDW;
   localparam int KW  = EW + AW;
   localparam logic [6:0] MAX7 = 7'(MAX_KEEP);

   knhs_pkg::state_type state_ff, state_in;

   logic [6:0]    keep_count_ff, keep_count_in;
   logic [DW-1:0] limit_ff, limit_in;
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] out_cnt_ff, out_cnt_in;
   logic [1:0]    type_ff, type_in;
   logic [EW-1:0] cand_ff, cand_in;
   logic          rd_vld_ff;
   logic [AW-1:0] rd_slot_ff;
   logic          found_ff, found_in;
   logic [KW-1:0] best_ff, best_in;
   logic [KW-1:0] prev_ff, prev_in;
   logic [DW-1:0] bound_ff, bound_in;
   logic          full_ff, full_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_bound_ff, rsp_bound_in;
   logic          rsp_full_ff, rsp_full_in;
   logic [6:0]    rsp_total_ff, rsp_total_in;
   logic          rsp_entry_ff, rsp_entry_in;
   logic [19:0]   rsp_id_ff, rsp_id_in;
   logic [DW-1:0] rsp_dist_ff, rsp_dist_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_accept, out_free, scan_state, scan_start, rd_issue, scan_done;
   logic          append_ok, full_now, job_read, emit_entry, emit_last;
   logic [6:0]    eff_keep, held7;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [KW-1:0] rd_key;
   logic          better;

   knhs_ram #(.WIDTH(EW), .DEPTH(MAX_KEEP)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_stall  = (state_ff != knhs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign eff_keep   = (keep_count_ff == 7'd0) ? 7'd1 :
                       (keep_count_ff > MAX7) ? MAX7 : keep_count_ff;
   assign held7      = 7'(held_ff);
   assign full_now   = held7 >= eff_keep;
   assign append_ok  = !full_now && (held7 < MAX7);
   assign job_read   = (type_ff == knhs_pkg::REQ_READ);
   assign emit_entry = job_read && (held_ff != '0);
   assign emit_last  = !emit_entry || (out_cnt_ff == held_ff - CW'(1));
   assign scan_state = (state_ff == knhs_pkg::ST_EVSCAN) ||
                       (state_ff == knhs_pkg::ST_STSCAN) ||
                       (state_ff == knhs_pkg::ST_READSCAN);
   assign rd_issue   = scan_state && (cnt_ff < held_ff);
   assign scan_done  = scan_state && !rd_issue && !rd_vld_ff;
   assign scan_start = ((state_in == knhs_pkg::ST_EVSCAN) ||
                        (state_in == knhs_pkg::ST_STSCAN) ||
                        (state_in == knhs_pkg::ST_READSCAN)) && (state_in != state_ff);
   assign rd_key     = {rd_data, rd_slot_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         knhs_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_type) inside
                  knhs_pkg::REQ_OFFER: state_in = append_ok ? knhs_pkg::ST_APPEND
                                                            : knhs_pkg::ST_EVSCAN;
                  knhs_pkg::REQ_BEGIN, knhs_pkg::REQ_READ: state_in = knhs_pkg::ST_STSCAN;
                  default: state_in = knhs_pkg::ST_IDLE;
               endcase
            end
         end
         knhs_pkg::ST_APPEND:  state_in = knhs_pkg::ST_STSCAN;
         knhs_pkg::ST_EVSCAN:  if (scan_done) state_in = knhs_pkg::ST_EVWRITE;
         knhs_pkg::ST_EVWRITE: state_in = knhs_pkg::ST_STSCAN;
         knhs_pkg::ST_STSCAN: begin
            if (scan_done) begin
               state_in = emit_entry ? knhs_pkg::ST_READSCAN : knhs_pkg::ST_EMIT;
            end
         end
         knhs_pkg::ST_READSCAN: if (scan_done) state_in = knhs_pkg::ST_EMIT;
         knhs_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = (emit_entry && !emit_last) ? knhs_pkg::ST_READSCAN
                                                     : knhs_pkg::ST_IDLE;
            end
         end
         default: state_in = knhs_pkg::ST_IDLE;
      endcase
   end

   // scan compare
   always_comb begin
      if (state_ff == knhs_pkg::ST_READSCAN) begin
         better = ((out_cnt_ff == '0) || (rd_key > prev_ff)) &&
                  (!found_ff || (rd_key < best_ff));
      end else begin
         better = !found_ff || (best_ff[KW-1:AW] < rd_data);
      end
   end

   // datapath and outputs
   always_comb begin
      keep_count_in = keep_count_ff;
      limit_in      = limit_ff;
      held_in       = held_ff;
      cnt_in        = cnt_ff;
      out_cnt_in    = out_cnt_ff;
      type_in       = type_ff;
      cand_in       = cand_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      prev_in       = prev_ff;
      bound_in      = bound_ff;
      full_in       = full_ff;
      wr_en         = 1'b0;
      wr_addr       = held_ff[AW-1:0];
      wr_data       = cand_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_bound_in  = rsp_bound_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            knhs_pkg::CSR_KEEP_COUNT:   keep_count_in = csr_write_data[6:0];
            knhs_pkg::CSR_SEARCH_LIMIT: limit_in = csr_write_data;
            default: ;
         endcase
      end

      if (req_accept) begin
         type_in = req_type;
         cand_in = {req_candidate_dist2, req_candidate_id[IDW-1:0]};
         if (req_type == knhs_pkg::REQ_BEGIN) begin
            held_in = '0;
         end
      end

      if (rd_issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (rd_vld_ff && better) begin
         found_in = 1'b1;
         best_in  = rd_key;
      end
      if (scan_start) begin
         cnt_in   = '0;
         found_in = 1'b0;
      end

      case (state_ff)
         knhs_pkg::ST_APPEND: begin
            wr_en   = 1'b1;
            held_in = held_ff + CW'(1);
         end
         knhs_pkg::ST_EVWRITE: begin
            wr_en   = 1'b1;
            wr_addr = best_ff[AW-1:0];
         end
         knhs_pkg::ST_STSCAN: begin
            if (scan_done) begin
               full_in    = full_now;
               bound_in   = (full_now && held_ff != '0) ? best_ff[KW-1:KW-DW] : limit_ff;
               out_cnt_in = '0;
            end
         end
         knhs_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bound_in = bound_ff;
               rsp_full_in  = full_ff;
               rsp_total_in = held7;
               rsp_entry_in = emit_entry;
               rsp_id_in    = emit_entry ? 20'(best_ff[AW+IDW-1:AW]) : 20'd0;
               rsp_dist_in  = emit_entry ? best_ff[KW-1:KW-DW] : '0;
               rsp_last_in  = emit_last;
               prev_in      = best_ff;
               out_cnt_in   = out_cnt_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= knhs_pkg::ST_IDLE;
         keep_count_ff <= 7'd50;
         limit_ff      <= '1;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         keep_count_ff <= keep_count_in;
         limit_ff      <= limit_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      out_cnt_ff   <= out_cnt_in;
      type_ff      <= type_in;
      cand_ff      <= cand_in;
      rd_slot_ff   <= cnt_ff[AW-1:0];
      found_ff     <= found_in;
      best_ff      <= best_in;
      prev_ff      <= prev_in;
      bound_ff     <= bound_in;
      full_ff      <= full_in;
      rsp_bound_ff <= rsp_bound_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_total_ff <= rsp_total_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bound_dist2 = rsp_bound_ff;
   assign rsp_store_full  = rsp_full_ff;
   assign rsp_kept_total  = rsp_total_ff;
   assign rsp_entry_valid = rsp_entry_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_out_dist2   = rsp_dist_ff;
   assign rsp_last        = rsp_last_ff;

   `KNHS_ASSERT(a_held_max, held_ff <= CW'(MAX_KEEP), "held count above capacity")
   `KNHS_ASSERT_NEXT(a_begin_clear, req_accept && req_type == knhs_pkg::REQ_BEGIN, held_ff == '0, "begin did not clear")
   `KNHS_ASSERT_NEXT(a_emit_only, state_ff != knhs_pkg::ST_EMIT, !$rose(rsp_valid_ff), "response outside emit")
   `KNHS_ASSERT(a_evict_found, state_ff != knhs_pkg::ST_EVWRITE || found_ff, "evict without victim")

endmodule
